/* sv/gma_pkg.sv */
// gma_pkg: shared sizes, register codes and structs for the glitch rejecting
// moving average filter. Used by the interfaces and by every module of the block but gma_ring_ram.
// No dependencies.
package gma_pkg;

   localparam int CHANNELS    = 8;
   localparam int RING_DEPTH  = 8;
   localparam int SAMPLE_BITS = 12;

   // fixed field widths of the channels
   localparam int CH_FIELD_W = 3;
   localparam int SAMPLE_W   = 12;
   localparam int THR_W      = 12;
   localparam int RUN_W      = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   localparam int CH_IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int WP_W         = $clog2(RING_DEPTH);
   localparam int FILL_W       = $clog2(RING_DEPTH + 1);
   localparam int SUM_W        = SAMPLE_BITS + $clog2(RING_DEPTH);
   localparam int RING_ENTRIES = CHANNELS * RING_DEPTH;
   localparam int RING_AW      = $clog2(RING_ENTRIES);

   // floor(sum / RING_DEPTH) as (sum * DIV_MULT) >> DIV_SHIFT, exact for any sum < 2**SUM_W
   localparam int DIV_SHIFT = SUM_W + $clog2(RING_DEPTH);
   localparam int MULT_W    = SUM_W + 1;
   localparam logic [MULT_W-1:0] DIV_MULT =
      MULT_W'(((64'd1 << DIV_SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

   localparam logic [RUN_W-1:0] RUN_MAX         = '1;
   localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(256);
   localparam logic [RUN_W-1:0] RUN_LIMIT_RESET = RUN_W'(3);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GLITCH_THRESHOLD = 1'b0,
      CSR_GLITCH_RUN_LIMIT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [FILL_W-1:0]      fill;
      logic [SUM_W-1:0]       sum;
      logic [SAMPLE_BITS-1:0] last;
      logic [RUN_W-1:0]       run;
   } chan_state_type;

   typedef struct packed {
      logic [THR_W-1:0] threshold;
      logic [RUN_W-1:0] run_limit;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] filtered_value;
      logic                glitch_seen;
      logic                fill_restarted;
      logic                still_filling;
   } result_type;

endpackage

/* sv/gma_ifs.sv */
// gma_ifs: valid/ready channel interfaces for sample requests, filtered
// responses and register writes. Depends on gma_pkg.
interface gma_req_if;
   logic                            valid;
   logic                            ready;
   logic [gma_pkg::CH_FIELD_W-1:0] channel;
   logic [gma_pkg::SAMPLE_W-1:0]   sample;

   modport source (output valid, output channel, output sample, input ready);
   modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface gma_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gma_pkg::SAMPLE_W-1:0] filtered_value;
   logic                          glitch_seen;
   logic                          fill_restarted;
   logic                          still_filling;

   modport source (output valid, output filtered_value, output glitch_seen,
                   output fill_restarted, output still_filling, input ready);
   modport sink   (input valid, input filtered_value, input glitch_seen,
                   input fill_restarted, input still_filling, output ready);
endinterface

interface gma_csr_if;
   logic                            valid;
   logic                            ready;
   logic [gma_pkg::CSR_IDX_W-1:0]  index;
   logic [gma_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/gma_ring_ram.sv */
// gma_ring_ram: generic single-write, single-read synchronous RAM with
// registered read data. No dependencies.
module gma_ring_ram #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 12,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/gma_state_store.sv */
// gma_state_store: per-channel filter state memory (fill count, sum, last
// accepted value, glitch run) with valid bits and write-first read. Depends on gma_pkg.
module gma_state_store (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rd_en,
   input  logic [gma_pkg::CH_IDX_W-1:0]    rd_addr,
   output gma_pkg::chan_state_type         rd_data,
   input  logic                            wr_en,
   input  logic [gma_pkg::CH_IDX_W-1:0]    wr_addr,
   input  gma_pkg::chan_state_type         wr_data
);

   gma_pkg::chan_state_type st_mem [gma_pkg::CHANNELS];
   logic [gma_pkg::CHANNELS-1:0] vld_ff;
   gma_pkg::chan_state_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         st_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // a write landing on the entry being read hands its data straight over
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else if (vld_ff[rd_addr]) begin
            rd_data_ff <= st_mem[rd_addr];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/gma_filter_core.sv */
// gma_filter_core: update logic for one sample: fill, glitch test, run count,
// running sum and ring average. Depends on gma_pkg.
module gma_filter_core (
   input  logic                              in_range,
   input  logic [gma_pkg::SAMPLE_BITS-1:0]   sample,
   input  gma_pkg::chan_state_type           cur,
   input  logic [gma_pkg::SAMPLE_BITS-1:0]   oldest,
   input  gma_pkg::cfg_type                  cfg,
   output gma_pkg::chan_state_type           nxt,
   output logic [gma_pkg::SAMPLE_BITS-1:0]   ring_value,
   output gma_pkg::result_type               result
);

   localparam int PROD_W = gma_pkg::SUM_W + gma_pkg::MULT_W;

   logic                            filling;
   logic [gma_pkg::SAMPLE_BITS-1:0] delta;
   logic                            glitch;
   logic [gma_pkg::RUN_W-1:0]       run_inc;
   logic                            restart;
   logic [gma_pkg::SAMPLE_BITS-1:0] accepted;
   logic [gma_pkg::SUM_W-1:0]       sum_full;
   logic [PROD_W-1:0]               avg_prod;
   logic [gma_pkg::SAMPLE_BITS-1:0] avg;

   always_comb begin
      filling  = cur.fill < gma_pkg::FILL_W'(gma_pkg::RING_DEPTH);
      delta    = (sample > cur.last) ? (sample - cur.last) : (cur.last - sample);
      glitch   = delta > cfg.threshold;
      run_inc  = (cur.run < gma_pkg::RUN_MAX) ? (cur.run + 1'b1) : cur.run;
      restart  = glitch && (run_inc > cfg.run_limit);
      accepted = glitch ? cur.last : sample;
      sum_full = cur.sum - gma_pkg::SUM_W'(oldest) + gma_pkg::SUM_W'(accepted);
      avg_prod = PROD_W'(sum_full) * PROD_W'(gma_pkg::DIV_MULT);
      avg      = gma_pkg::SAMPLE_BITS'(avg_prod >> gma_pkg::DIV_SHIFT);
   end

   always_comb begin
      nxt        = cur;
      ring_value = sample;
      result     = '0;
      priority if (!in_range) begin
         nxt = cur;
      end else if (filling) begin
         nxt.sum  = (cur.fill == '0) ? gma_pkg::SUM_W'(sample)
                                     : cur.sum + gma_pkg::SUM_W'(sample);
         nxt.fill = cur.fill + 1'b1;
         nxt.last = sample;
         result.filtered_value = gma_pkg::SAMPLE_W'(sample);
         result.still_filling  = 1'b1;
      end else begin
         nxt.sum  = sum_full;
         nxt.fill = restart ? '0 : cur.fill;
         nxt.last = accepted;
         if (!glitch) begin
            nxt.run = '0;
         end else if (restart) begin
            nxt.run = '0;
         end else begin
            nxt.run = run_inc;
         end
         ring_value            = accepted;
         result.filtered_value = gma_pkg::SAMPLE_W'(avg);
         result.glitch_seen    = glitch;
         result.fill_restarted = restart;
      end
   end

endmodule

/* sv/glitch_reject_moving_average.sv */
// glitch_reject_moving_average: top level; accepts samples, keeps per-channel
// state in gma_state_store and the sample rings in gma_ring_ram, updates through gma_filter_core.
// Depends on gma_pkg, gma_ifs, gma_ring_ram, gma_state_store and gma_filter_core.
//
//   port     dir  payload                                         handshake
//   req_bus  in   channel, sample                                 valid/ready
//   rsp_bus  out  filtered_value, glitch_seen, fill_restarted,    valid/ready
//                 still_filling
//   csr_bus  in   index, data                                     valid/ready, always ready
//
// One transaction per cycle sustained while the response is not stalled. Accepting a request loads
// the state and ring reads and the update stage; when the update stage advances, the update goes
// into the output register and both memories are written back.
// Reset clears the write pointers, the state valid bits, the stages and the
// registers to their defaults; no clearing pass is needed.
// A stalled response holds the update stage, and req_bus.ready drops only then.
module glitch_reject_moving_average (
   input  logic       clock,
   input  logic       reset,
   gma_req_if.sink    req_bus,
   gma_rsp_if.source  rsp_bus,
   gma_csr_if.sink    csr_bus
);

   gma_pkg::cfg_type cfg_ff;

   logic [gma_pkg::WP_W-1:0] wp_ff [gma_pkg::CHANNELS];

   logic                            acc;
   logic                            in_range;
   logic [gma_pkg::CH_IDX_W-1:0]    ch_idx;
   logic [gma_pkg::WP_W-1:0]        wp_cur;
   logic [gma_pkg::WP_W-1:0]        wp_next;
   logic [gma_pkg::RING_AW-1:0]     ring_raddr;

   logic                            b_valid_ff;
   logic                            b_in_range_ff;
   logic [gma_pkg::CH_IDX_W-1:0]    b_ch_ff;
   logic [gma_pkg::SAMPLE_BITS-1:0] b_sample_ff;
   logic [gma_pkg::RING_AW-1:0]     b_addr_ff;
   logic                            b_go;

   gma_pkg::chan_state_type         cur_state;
   gma_pkg::chan_state_type         nxt_state;
   logic [gma_pkg::SAMPLE_BITS-1:0] oldest;
   logic [gma_pkg::SAMPLE_BITS-1:0] ring_value;
   logic                            mem_we;
   gma_pkg::result_type             result;

   logic                            rsp_valid_ff;
   gma_pkg::result_type             rsp_result_ff;

   // configuration registers
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= gma_pkg::THRESHOLD_RESET;
         cfg_ff.run_limit <= gma_pkg::RUN_LIMIT_RESET;
      end else if (csr_bus.valid) begin
         unique case (gma_pkg::csr_index_type'(csr_bus.index))
            gma_pkg::CSR_GLITCH_THRESHOLD: begin
               cfg_ff.threshold <= gma_pkg::THR_W'(csr_bus.data);
            end
            gma_pkg::CSR_GLITCH_RUN_LIMIT: begin
               cfg_ff.run_limit <= gma_pkg::RUN_W'(csr_bus.data);
            end
         endcase
      end
   end

   // request side: pointer lookup and memory read issue
   assign b_go          = b_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !b_valid_ff || b_go;
   assign acc           = req_bus.valid && req_bus.ready;
   assign in_range      = 32'(req_bus.channel) < gma_pkg::CHANNELS;
   assign ch_idx        = gma_pkg::CH_IDX_W'(req_bus.channel);
   assign wp_cur        = wp_ff[ch_idx];
   assign wp_next       = (32'(wp_cur) == gma_pkg::RING_DEPTH - 1) ? '0 : wp_cur + 1'b1;
   assign ring_raddr    = gma_pkg::RING_AW'(32'(ch_idx) * gma_pkg::RING_DEPTH + 32'(wp_cur));

   // the pointer advances on every in-range sample, so it is settled at accept time
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '{default: '0};
      end else if (acc && in_range) begin
         wp_ff[ch_idx] <= wp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (acc) begin
         b_valid_ff <= 1'b1;
      end else if (b_go) begin
         b_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         b_in_range_ff <= in_range;
         b_ch_ff       <= ch_idx;
         b_sample_ff   <= gma_pkg::SAMPLE_BITS'(req_bus.sample);
         b_addr_ff     <= ring_raddr;
      end
   end

   assign mem_we = b_go && b_in_range_ff;

   gma_state_store u_state (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (acc),
      .rd_addr (ch_idx),
      .rd_data (cur_state),
      .wr_en   (mem_we),
      .wr_addr (b_ch_ff),
      .wr_data (nxt_state)
   );

   gma_ring_ram #(
      .DEPTH (gma_pkg::RING_ENTRIES),
      .WIDTH (gma_pkg::SAMPLE_BITS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (b_addr_ff),
      .wr_data (ring_value),
      .rd_en   (acc),
      .rd_addr (ring_raddr),
      .rd_data (oldest)
   );

   gma_filter_core u_core (
      .in_range   (b_in_range_ff),
      .sample     (b_sample_ff),
      .cur        (cur_state),
      .oldest     (oldest),
      .cfg        (cfg_ff),
      .nxt        (nxt_state),
      .ring_value (ring_value),
      .result     (result)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (b_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b_go) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.filtered_value = rsp_result_ff.filtered_value;
   assign rsp_bus.glitch_seen    = rsp_result_ff.glitch_seen;
   assign rsp_bus.fill_restarted = rsp_result_ff.fill_restarted;
   assign rsp_bus.still_filling  = rsp_result_ff.still_filling;

`ifndef SYNTHESIS
   // ring write-back never collides with the entry read for the next transaction
   a_ring_no_collision: assert property (@(posedge clock) disable iff (reset)
      (mem_we && acc && in_range) |-> (b_addr_ff != ring_raddr))
      else $error("ring write and read hit the same entry");

   a_restart_is_glitch: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.fill_restarted) |-> rsp_bus.glitch_seen)
      else $error("fill restart without a glitch");

   a_fill_no_glitch: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.still_filling && rsp_bus.glitch_seen))
      else $error("glitch flagged while filling");

   a_update_lands: assert property (@(posedge clock) disable iff (reset)
      b_go |=> rsp_bus.valid)
      else $error("update stage advanced without a response");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !b_go) |=> (b_valid_ff && $stable(b_ch_ff) && $stable(b_addr_ff)))
      else $error("stalled update stage lost its transaction");
`endif

endmodule
